[rtl/modbus_rtu_response_checker_top_macros.svh]
// Assertion macros for the response checker assertions in mrc_checker.sv.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_TOP_MACROS_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define MRC_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define MRC_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mrc_pkg.sv]
// Types, constants and helper functions of the Modbus RTU response checker.
`default_nettype none

package mrc_pkg;

  localparam int BUF_BYTES = 256;
  // Length and count width: holds BUF_BYTES + 2 and 5 + 255.
  localparam int LEN_W = ($clog2(BUF_BYTES + 3) > 9) ? $clog2(BUF_BYTES + 3) : 9;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_FIELDS_W = 52;
  localparam int OUT_TDATA_W  = 56;

  localparam logic [7:0]  FUNC_READ_HOLD    = 8'h03;
  localparam logic [7:0]  FUNC_READ_INPUT   = 8'h04;
  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  FUNC_WRITE_MULTI  = 8'h10;
  localparam logic [7:0]  FUNC_EXC_BIT      = 8'h80;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] FP_MULT           = 16'd131;
  localparam int          LEN_EXCEPTION     = 5;
  localparam int          LEN_WRITE         = 8;
  localparam int          LEN_READ_OVERHEAD = 5;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_CRC_ERR        = 3'd1,
    ST_ADDR_MISMATCH  = 3'd2,
    ST_EXCEPTION      = 3'd3,
    ST_FUNC_MISMATCH  = 3'd4,
    ST_COUNT_MISMATCH = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADDR       = 2'd0,
    CFG_FUNC       = 2'd1,
    CFG_COUNT      = 2'd2,
    CFG_WRITE_MODE = 2'd3
  } cfg_index_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    status_t     status;
    logic [7:0]  exception_code;
    logic [15:0] fingerprint;
    logic [8:0]  frame_length;
  } result_t;

  // Byte-wide CRC-16 update, reflected polynomial, LSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic is_read_func(input logic [7:0] f);
    return (f == FUNC_READ_HOLD) || (f == FUNC_READ_INPUT);
  endfunction

endpackage

`default_nettype wire

[rtl/modbus_rtu_response_checker_top.sv]
// Top level of the Modbus RTU response checker.
// Usage:
//  - s_axis: one word per received byte. tuser = cmd (0 byte, 1 restart),
//    tdata = rx_byte. A restart clears the frame state, never the config.
//  - m_axis: one word per result. tuser = kind (0 data byte, 1 frame status).
//    Data words carry read payload bytes in order; one status word ends a frame.
//    After the status word, bytes are ignored until a restart word.
//  - cfg: index 0 expected_addr, 1 expected_func, 2 expected_count,
//    3 write_mode. cfg_ready is always high; write only while idle.
// Timing: input register, one pass of logic (byte-wide CRC step, frame checks,
//  x131 fingerprint product), result register. An accepted word passes the
//  logic into the result register; one word per cycle while m_tready is high.
// Stall: while m_tready is low the result word holds and one more input word
//  can sit in the input register; s_tready then drops until m_tready returns.
// Reset (rst, synchronous): both stages empty, frame state cleared, config at
//  addr 0, func 0x03, count 1, read mode.
`default_nettype none

module modbus_rtu_response_checker_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input word: tuser = cmd
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [mrc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [7:0] rx_byte
  input  wire logic                                s_axis_tuser,  // [0] cmd
  // result word
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [7:0] data_byte, [15:8] data_index, [18:16] status, [26:19] exception_code,
  // [42:27] fingerprint, [51:43] frame_length, [55:52] zero
  output logic [mrc_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  output logic                                     m_axis_tuser,  // [0] kind
  // config write
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mrc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mrc_pkg::*;

  item_t   in_item, held_item;
  result_t res, out_res;
  logic    held_valid, advance, out_free, res_valid;

  assign cfg_ready = 1'b1;
  assign in_item   = '{cmd: cmd_t'(s_axis_tuser), rx_byte: s_axis_tdata};
  // held word moves through the logic when the result register can take it
  assign advance   = held_valid && out_free;

  mrc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  mrc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (advance),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  mrc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                         out_res.frame_length, out_res.fingerprint,
                         out_res.exception_code, out_res.status,
                         out_res.data_index, out_res.data_byte};

endmodule

`default_nettype wire

[rtl/mrc_in_stage.sv]
// Input register of the response checker.
`default_nettype none

module mrc_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mrc_pkg::item_t in_item,
  input  wire logic          advance,
  output logic               held_valid,
  output mrc_pkg::item_t     held_item
);
  import mrc_pkg::*;

  logic accept;

  assign in_ready = !held_valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= accept || (held_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

[rtl/mrc_engine.sv]
// Frame tracking state, CRC, payload sum and result decision.
`default_nettype none

module mrc_engine (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [mrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             take,
  input  wire mrc_pkg::item_t                   item,
  output logic                                  res_valid,
  output mrc_pkg::result_t                      res
);
  import mrc_pkg::*;

  // config
  logic [7:0] expected_addr;
  logic [7:0] expected_func;
  logic [6:0] expected_count;
  logic       write_mode;

  // reception state
  logic [LEN_W-1:0] received_count, received_count_next;
  logic [LEN_W-1:0] expected_length, expected_length_next;
  logic [7:0]       function_byte, function_byte_next;
  logic [7:0]       count_byte, count_byte_next;
  logic [7:0]       addr_byte, addr_byte_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [15:0]      held_bytes, held_bytes_next;
  logic [15:0]      payload_sum, payload_sum_next;
  logic             frame_done, frame_done_next;

  logic [7:0]       b;
  logic [LEN_W-1:0] pos, count_inc, len, el_sum, idx_full;
  logic             blocked, dropped, emit_data, is_rd;
  logic [15:0]      crc_rx, fp_calc;
  status_t          st;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_addr  <= 8'd0;
      expected_func  <= FUNC_READ_HOLD;
      expected_count <= 7'd1;
      write_mode     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_ADDR:       expected_addr  <= cfg_data;
        CFG_FUNC:       expected_func  <= cfg_data;
        CFG_COUNT:      expected_count <= cfg_data[6:0];
        CFG_WRITE_MODE: write_mode     <= cfg_data[0];
        default:        expected_addr  <= expected_addr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      received_count  <= '0;
      expected_length <= '0;
      function_byte   <= 8'd0;
      count_byte      <= 8'd0;
      addr_byte       <= 8'd0;
      running_crc     <= CRC_INIT;
      held_bytes      <= 16'd0;
      payload_sum     <= 16'd0;
      frame_done      <= 1'b0;
    end else begin
      received_count  <= received_count_next;
      expected_length <= expected_length_next;
      function_byte   <= function_byte_next;
      count_byte      <= count_byte_next;
      addr_byte       <= addr_byte_next;
      running_crc     <= running_crc_next;
      held_bytes      <= held_bytes_next;
      payload_sum     <= payload_sum_next;
      frame_done      <= frame_done_next;
    end
  end

  assign b         = item.rx_byte;
  assign pos       = received_count;
  assign count_inc = received_count + LEN_W'(1);
  assign blocked   = frame_done || (received_count >= LEN_W'(BUF_BYTES));
  // address filter on the first byte of a frame
  assign dropped   = (received_count == '0) && (expected_addr != 8'd0) && (b != expected_addr);
  assign idx_full  = pos - LEN_W'(3);
  assign crc_rx    = {held_bytes_next[7:0], held_bytes_next[15:8]};
  assign fp_calc   = payload_sum_next * FP_MULT;

  // Check order: crc, address, exception (read mode only), function, count.
  always_comb begin
    if (crc_rx != running_crc_next) begin
      st = ST_CRC_ERR;
    end else if (addr_byte_next != expected_addr) begin
      st = ST_ADDR_MISMATCH;
    end else if (!write_mode && ((function_byte_next & FUNC_EXC_BIT) != 8'd0)) begin
      st = ST_EXCEPTION;
    end else if (function_byte_next != expected_func) begin
      st = ST_FUNC_MISMATCH;
    end else if (!write_mode && is_read_func(function_byte_next) &&
                 (count_byte_next != {expected_count, 1'b0})) begin
      st = ST_COUNT_MISMATCH;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    received_count_next  = received_count;
    expected_length_next = expected_length;
    function_byte_next   = function_byte;
    count_byte_next      = count_byte;
    addr_byte_next       = addr_byte;
    running_crc_next     = running_crc;
    held_bytes_next      = held_bytes;
    payload_sum_next     = payload_sum;
    frame_done_next      = frame_done;
    res_valid            = 1'b0;
    res                  = '0;
    emit_data            = 1'b0;
    len                  = '0;
    is_rd                = 1'b0;
    el_sum               = '0;

    if (take) begin
      if (item.cmd == CMD_RESTART) begin
        received_count_next  = '0;
        expected_length_next = '0;
        function_byte_next   = 8'd0;
        count_byte_next      = 8'd0;
        addr_byte_next       = 8'd0;
        running_crc_next     = CRC_INIT;
        held_bytes_next      = 16'd0;
        payload_sum_next     = 16'd0;
        frame_done_next      = 1'b0;
      end else if (!blocked && !dropped) begin
        // CRC lags two bytes behind: the last two are the received CRC
        if (pos >= LEN_W'(2)) begin
          running_crc_next = crc_feed(running_crc, held_bytes[15:8]);
        end
        held_bytes_next     = {held_bytes[7:0], b};
        received_count_next = count_inc;
        if (pos == LEN_W'(0)) begin
          addr_byte_next = b;
        end else if (pos == LEN_W'(1)) begin
          function_byte_next = b;
        end else if (pos == LEN_W'(2)) begin
          count_byte_next = b;
        end

        // header bytes including this one, before any restart below
        is_rd  = is_read_func(function_byte_next);
        el_sum = LEN_W'(LEN_READ_OVERHEAD) + LEN_W'(count_byte_next);

        if (!write_mode && (expected_length == '0) && (count_inc >= LEN_W'(2))) begin
          if ((function_byte_next & FUNC_EXC_BIT) != 8'd0) begin
            expected_length_next = LEN_W'(LEN_EXCEPTION);
          end else if ((function_byte_next == FUNC_WRITE_SINGLE) ||
                       (function_byte_next == FUNC_WRITE_MULTI)) begin
            expected_length_next = LEN_W'(LEN_WRITE);
          end
        end

        if (!write_mode && (expected_length_next == '0) && (count_inc >= LEN_W'(3)) &&
            is_rd && (el_sum > LEN_W'(BUF_BYTES))) begin
          // read too long for the buffer: start over
          received_count_next  = '0;
          expected_length_next = '0;
          function_byte_next   = 8'd0;
          count_byte_next      = 8'd0;
          addr_byte_next       = 8'd0;
          running_crc_next     = CRC_INIT;
          held_bytes_next      = 16'd0;
          payload_sum_next     = 16'd0;
          frame_done_next      = 1'b0;
        end else begin
          if (!write_mode && (expected_length_next == '0) && (count_inc >= LEN_W'(3)) &&
              is_rd) begin
            expected_length_next = el_sum;
          end

          len = write_mode ? LEN_W'(LEN_WRITE) : expected_length_next;

          emit_data = !write_mode && is_rd && (expected_length_next != '0) &&
                      (pos >= LEN_W'(3)) && ((pos + LEN_W'(2)) < expected_length_next);

          if (emit_data) begin
            payload_sum_next = payload_sum + {8'd0, b};
            res_valid        = 1'b1;
            res.kind         = KIND_DATA;
            res.data_byte    = b;
            res.data_index   = idx_full[7:0];
          end else if ((len != '0) && (count_inc >= len)) begin
            frame_done_next    = 1'b1;
            res_valid          = 1'b1;
            res.kind           = KIND_STATUS;
            res.status         = st;
            res.exception_code = (st == ST_EXCEPTION) ? count_byte_next : 8'd0;
            res.fingerprint    = fp_calc;
            res.frame_length   = len[8:0];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/mrc_out_stage.sv]
// Result register of the response checker.
`default_nettype none

module mrc_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic             res_valid,
  input  wire mrc_pkg::result_t res,
  output logic                  out_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mrc_pkg::result_t      out_res
);
  import mrc_pkg::*;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/mrc_checker.sv]
// Port-level assertions for the response checker, bound to the top level.
`default_nettype none
`include "modbus_rtu_response_checker_top_macros.svh"

module mrc_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [mrc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire logic                             m_axis_tuser
);
  import mrc_pkg::*;

  // stalled result holds
  `MRC_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // data word: status fields all zero
  `MRC_ASSERT_NOW(a_data_clean, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[55:16] == 40'd0, "data word carries status fields")

  // status word: no data byte or index, status code in range
  `MRC_ASSERT_NOW(a_status_clean, clk, rst, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[15:0] == 16'd0) && (m_axis_tdata[18:16] != 3'd6) && (m_axis_tdata[18:16] != 3'd7) && (m_axis_tdata[55:52] == 4'd0), "bad status word")

  // exception code only with exception status
  `MRC_ASSERT_NOW(a_exc_code, clk, rst, m_axis_tvalid && m_axis_tuser && (m_axis_tdata[18:16] != ST_EXCEPTION), m_axis_tdata[26:19] == 8'd0, "exception code without exception")

  // reset empties the result register
  `MRC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid, "result valid after reset")

endmodule

bind modbus_rtu_response_checker_top mrc_checker u_mrc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
